>>> rtl/prc_pkg.sv
// Package for the per-title replay check block.
// Holds status codes, title constants and the controller/datapath interface structs.
// No dependencies.
package prc_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_TITLE   = 3'd1;
    localparam logic [2:0] ST_BAD_COUNTER = 3'd2;
    localparam logic [2:0] ST_REPLAY      = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;

    // Input checks
    localparam logic [7:0]  TITLE_BYTES  = 8'd8;
    localparam logic [31:0] ZERO_COUNTER = 32'd0;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch an accepted input transaction, clear the scan
        logic scan_step; // read the next table entry and advance the index
        logic decide;    // commit the table update and load the result register
    } prc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pre_bad;    // title or counter check failed
        logic count_zero; // table holds no entries
        logic scan_last;  // current scan index is the last filled entry
        logic out_free;   // result register can take a new result
    } prc_stat_t;

endpackage

>>> rtl/prc_ctrl.sv
// Controller state machine for the per-title replay check block.
// Sequences capture, table scan and decision; depends on prc_pkg.
module prc_ctrl
    import prc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  prc_stat_t stat,
    output prc_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_DECIDE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    // Advance state and issue commands
    always_comb begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.decide    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.pre_bad || stat.count_zero) begin
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (stat.out_free) begin
                    cmd.decide = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/prc_datapath.sv
// Datapath for the per-title replay check block: input registers, title and
// counter memories, fill count, scan compare and result register. Depends on prc_pkg.
module prc_datapath
    import prc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_present,
    input  logic [7:0]  in_length,
    input  logic [63:0] in_title,
    input  logic [31:0] in_counter,
    input  prc_cmd_t    cmd,
    output prc_stat_t   stat,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [2:0]  out_status,
    output logic        out_new_entry
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Table memories; valid entries always form the prefix below the fill count
    logic [63:0] title_mem [ENTRIES];
    logic [31:0] high_mem  [ENTRIES];

    logic [63:0]      title_reg;
    logic [31:0]      counter_reg;
    logic [2:0]       pre_status_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [63:0]      rd_title_reg;
    logic [31:0]      rd_high_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [31:0]      hit_high_reg;
    logic             m_valid_reg;
    logic [2:0]       m_status_reg;
    logic             m_new_reg;

    logic [2:0]       pre_status_next;
    logic             match;
    logic             full;
    logic [2:0]       res_status;
    logic             res_new;
    logic             high_we;
    logic             ins_we;
    logic [IDX_W-1:0] ins_addr;

    // Classify the incoming transaction before any table access
    always_comb begin
        if (!in_present || in_length != TITLE_BYTES) begin
            pre_status_next = ST_BAD_TITLE;
        end else if (in_counter == ZERO_COUNTER) begin
            pre_status_next = ST_BAD_COUNTER;
        end else begin
            pre_status_next = ST_OK;
        end
    end

    // Capture the input transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            title_reg      <= in_title;
            counter_reg    <= in_counter;
            pre_status_reg <= pre_status_next;
        end
    end

    // Status to the controller
    assign full            = (count_reg == CNT_W'(ENTRIES));
    assign stat.pre_bad    = (pre_status_reg != ST_OK);
    assign stat.count_zero = (count_reg == '0);
    assign stat.scan_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign stat.out_free   = !m_valid_reg || out_ready;

    // Compare the entry read in the previous cycle; keep the lowest match
    assign match = rd_valid_reg && !hit_reg && (rd_title_reg == title_reg);

    // Decide the result and the table update
    assign ins_addr = count_reg[IDX_W-1:0];
    always_comb begin
        res_status = pre_status_reg;
        res_new    = 1'b0;
        high_we    = 1'b0;
        ins_we     = 1'b0;
        if (pre_status_reg == ST_OK) begin
            if (hit_reg) begin
                if (counter_reg <= hit_high_reg) begin
                    res_status = ST_REPLAY;
                end else begin
                    high_we = cmd.decide;
                end
            end else if (!full) begin
                res_new = 1'b1;
                ins_we  = cmd.decide;
            end else begin
                res_status = ST_FULL;
            end
        end
    end

    // Title memory: insert on a miss, read one entry per scan step
    always_ff @(posedge aclk) begin
        if (ins_we) begin
            title_mem[ins_addr] <= title_reg;
        end
        rd_title_reg <= title_mem[idx_reg];
    end

    // Counter memory: write on insert or on an accepted hit
    always_ff @(posedge aclk) begin
        if (ins_we) begin
            high_mem[ins_addr] <= counter_reg;
        end else if (high_we) begin
            high_mem[hit_idx_reg] <= counter_reg;
        end
        rd_high_reg <= high_mem[idx_reg];
    end

    // Scan index, read pipeline and hit tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.scan_step;
            if (cmd.capture) begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end else begin
                if (cmd.scan_step) begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (match) begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step) begin
            rd_idx_reg <= idx_reg;
        end
        if (match) begin
            hit_idx_reg  <= rd_idx_reg;
            hit_high_reg <= rd_high_reg;
        end
    end

    // Fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ins_we) begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    // Result register; drop the valid flag once the transaction is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.decide) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            m_status_reg <= res_status;
            m_new_reg    <= res_new;
        end
    end

    assign out_valid     = m_valid_reg;
    assign out_status    = m_status_reg;
    assign out_new_entry = m_new_reg;

endmodule

>>> rtl/per_title_replay_check.sv
// Top level of the per-title replay check block.
// Joins the controller (prc_ctrl) and the datapath (prc_datapath); depends on prc_pkg.
//
// Usage:
//   The slave stream takes one check request per transaction; the master stream
//   returns one result per request, in order. A transaction moves when tvalid
//   and tready are both high at a rising edge of aclk.
//   After acceptance, a well-formed request passes a check state, a scan state
//   that reads one table entry per step from the title and counter memories
//   for each stored title, a compare drain state and a decision state; a
//   request with a bad title or a zero counter, or one that meets an empty
//   table, goes from the check state straight to the decision state.
//   The block takes one request at a time; s_tready rises again together with
//   the valid flag of the loaded result, and the scan over the table grows
//   with the number of stored titles.
//   Reset (aresetn low, synchronous) empties the table and drops any pending
//   result. Table contents are kept as a filled prefix tracked by a count,
//   so no clearing pass is needed.
//   When the receiver stalls, the result waits in the output register and the
//   next request is still accepted and processed; its decision waits until
//   the output register is free.
module per_title_replay_check
    import prc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] title_present, [8:1] title_length, [72:9] system_title,
    // [104:73] invocation_counter, [111:105] zero
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] status, [3] new_entry, [7:4] zero
    output logic [7:0]   m_tdata
);

    prc_cmd_t   cmd;
    prc_stat_t  stat;
    logic [2:0] status;
    logic       new_entry;

    prc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    prc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_present    (s_tdata[0]),
        .in_length     (s_tdata[8:1]),
        .in_title      (s_tdata[72:9]),
        .in_counter    (s_tdata[104:73]),
        .cmd           (cmd),
        .stat          (stat),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_status    (status),
        .out_new_entry (new_entry)
    );

    // Pack the result transaction
    assign m_tdata = {4'b0000, new_entry, status};

endmodule

>>> sim/replay_checker.sv
// Scoreboard for the per-title replay check block: watches both stream channels,
// predicts each verdict from its own copy of the title table and compares in order.
// Depends on prc_pkg for status codes and title constants.
module replay_checker
    import prc_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // [0] title_present, [8:1] title_length, [72:9] system_title,
    // [104:73] invocation_counter, [111:105] zero
    input  logic [111:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] status, [3] new_entry, [7:4] zero
    input  logic [7:0]   m_tdata,
    output int           fail_count,
    output int           pending,
    output int           results_seen,
    output int           inserts_seen,
    output int           replays_seen,
    output int           full_seen,
    output int           malformed_seen
);

    // One result transaction, laid out as on m_tdata[3:0]
    typedef struct packed {
        logic       new_entry;
        logic [2:0] status;
    } verdict_t;

    // Shadow copy of the title table
    logic        slot_used    [ENTRIES];
    logic [63:0] slot_name    [ENTRIES];
    logic [31:0] slot_counter [ENTRIES];

    verdict_t verdicts_due[$];

    int fails, results, inserts, replays, fulls, malformed;

    // Run the checks on one request and update the shadow table
    function automatic verdict_t judge_request(input logic present, input logic [7:0] length,
                                               input logic [63:0] title,
                                               input logic [31:0] counter);
        verdict_t v;
        int       hit;
        int       free_slot;
        v.status    = ST_OK;
        v.new_entry = 1'b0;
        hit         = -1;
        free_slot   = -1;
        if (!present || length != TITLE_BYTES) begin
            v.status = ST_BAD_TITLE;
        end else if (counter == ZERO_COUNTER) begin
            v.status = ST_BAD_COUNTER;
        end else begin
            // lowest matching slot wins, new titles go to the lowest free slot
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot_used[i]) begin
                    if (hit < 0 && slot_name[i] == title) hit = i;
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit >= 0) begin
                if (counter <= slot_counter[hit]) v.status = ST_REPLAY;
                else slot_counter[hit] = counter;
            end else if (free_slot >= 0) begin
                slot_used[free_slot]    = 1'b1;
                slot_name[free_slot]    = title;
                slot_counter[free_slot] = counter;
                v.new_entry             = 1'b1;
            end else begin
                v.status = ST_FULL;
            end
        end
        return v;
    endfunction

    always @(posedge aclk) begin
        verdict_t want;
        verdict_t got;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
            verdicts_due.delete();
            fails     = 0;
            results   = 0;
            inserts   = 0;
            replays   = 0;
            fulls     = 0;
            malformed = 0;
        end else begin
            // Retire the oldest expectation first: a result never belongs to a
            // request accepted at the same edge
            if (m_tvalid && m_tready) begin
                got = verdict_t'(m_tdata[3:0]);
                if (verdicts_due.size() == 0) begin
                    $error("result with nothing outstanding: status %0d new_entry %0d",
                           got.status, got.new_entry);
                    fails++;
                end else begin
                    want = verdicts_due.pop_front();
                    results++;
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fails++;
                    end
                    if (got.new_entry !== want.new_entry) begin
                        $error("new_entry mismatch: expected %0d, actual %0d",
                               want.new_entry, got.new_entry);
                        fails++;
                    end
                    if (want.new_entry) inserts++;
                    case (want.status)
                        ST_REPLAY:                    replays++;
                        ST_FULL:                      fulls++;
                        ST_BAD_TITLE, ST_BAD_COUNTER: malformed++;
                        default: ;
                    endcase
                end
            end
            // Predict the verdict of a newly accepted request
            if (s_tvalid && s_tready) begin
                verdicts_due.push_back(judge_request(s_tdata[0], s_tdata[8:1],
                                                     s_tdata[72:9], s_tdata[104:73]));
            end
        end
        fail_count     <= fails;
        pending        <= verdicts_due.size();
        results_seen   <= results;
        inserts_seen   <= inserts;
        replays_seen   <= replays;
        full_seen      <= fulls;
        malformed_seen <= malformed;
    end

endmodule

>>> sim/testbench.sv
// Top of the replay check simulation: clock, reset, request and result stream drivers.
// Instantiates per_title_replay_check and replay_checker; depends on prc_pkg.
module testbench
    import prc_pkg::*;
();

    localparam int ENTRIES     = 16;
    localparam int POOL        = 22;
    localparam int RANDOM_REQS = 1350;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // [0] title_present, [8:1] title_length, [72:9] system_title,
    // [104:73] invocation_counter, [111:105] zero
    logic [111:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // [2:0] status, [3] new_entry, [7:4] zero
    logic [7:0]   m_tdata;

    int fail_count, pending, results_seen, inserts_seen, replays_seen, full_seen;
    int malformed_seen;
    int cycle_count;
    int sent;
    bit steady;
    bit hold_done;

    // Sender titles for the random part and the last fresh counter sent for each
    logic [63:0] pool_title [POOL];
    logic [31:0] pool_last  [POOL];

    per_title_replay_check #(.ENTRIES(ENTRIES)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    replay_checker #(.ENTRIES(ENTRIES)) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen),
        .inserts_seen   (inserts_seen),
        .replays_seen   (replays_seen),
        .full_seen      (full_seen),
        .malformed_seen (malformed_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop on a hang
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one request, hold it until the transaction completes, then maybe idle
    task automatic offer(input logic present, input logic [7:0] length,
                         input logic [63:0] title, input logic [31:0] counter);
        s_tdata  <= {7'd0, counter, title, length, present};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent++;
        if (!steady && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // Result side: random stalls, one long hold-off to back the block up,
    // and a stretch that always takes results
    initial begin
        hold_done = 1'b0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!hold_done && results_seen >= 200) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            if (results_seen >= 520 && results_seen < 760) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(99) >= 29);
            @(posedge aclk);
        end
    end

    // Request side and verdict
    initial begin
        int          k;
        int          pick;
        logic [31:0] ctr;
        logic [31:0] step;
        sent     = 0;
        steady   = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        aresetn  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Malformed titles, including a missing title with a zero counter
        offer(1'b0, TITLE_BYTES, 64'h1111_2222_3333_4444, 32'd5);
        offer(1'b1, 8'd0,        64'h1111_2222_3333_4444, 32'd5);
        offer(1'b1, 8'd255,      64'h1111_2222_3333_4444, 32'd5);
        offer(1'b1, 8'd7,        64'h1111_2222_3333_4444, 32'd5);
        offer(1'b1, 8'd9,        64'h1111_2222_3333_4444, 32'd5);
        offer(1'b0, 8'd0,        64'h0,                   ZERO_COUNTER);
        // Zero counter with a good title
        offer(1'b1, TITLE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, ZERO_COUNTER);
        // Insert, replay with equal and lower counters, advance to the top value
        offer(1'b1, TITLE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
        offer(1'b1, TITLE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
        offer(1'b1, TITLE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 32'd2);
        offer(1'b1, TITLE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
        offer(1'b1, TITLE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        offer(1'b1, TITLE_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        // All-zero title beside the all-ones one
        offer(1'b1, TITLE_BYTES, 64'h0, 32'hFFFF_FFFF);
        offer(1'b1, TITLE_BYTES, 64'h0, 32'hFFFF_FFFE);
        offer(1'b1, TITLE_BYTES, 64'h0, ZERO_COUNTER);
        offer(1'b1, TITLE_BYTES, 64'h0123_4567_89AB_CDEF, 32'h8000_0000);
        offer(1'b1, TITLE_BYTES, 64'h0123_4567_89AB_CDEF, 32'h7FFF_FFFF);
        offer(1'b1, TITLE_BYTES, 64'h0123_4567_89AB_CDEF, 32'h8000_0001);

        // More titles than slots, so the table fills and refuses new senders
        for (int i = 0; i < POOL; i++) begin
            pool_title[i] = {$urandom, $urandom};
            pool_last[i]  = 32'd0;
        end

        for (int n = 0; n < RANDOM_REQS; n++) begin
            steady = (n >= 500 && n < 750);
            pick   = $urandom_range(99);
            k      = $urandom_range(POOL - 1);
            if (pick < 14) begin
                // noise: any field values at all
                offer(1'($urandom_range(1)), 8'($urandom_range(255)), {$urandom, $urandom},
                      ($urandom_range(3) == 0) ? ZERO_COUNTER : $urandom);
            end else if (pick < 20) begin
                offer(1'b1, TITLE_BYTES, pool_title[k], ZERO_COUNTER);
            end else if (pick < 32 && pool_last[k] != 0) begin
                // replay: equal to or below the last fresh counter
                step = (pool_last[k] > 40) ? 32'd40 : pool_last[k] - 1;
                offer(1'b1, TITLE_BYTES, pool_title[k],
                      pool_last[k] - $urandom_range(step, 0));
            end else begin
                // fresh counter, now and then with a large jump
                if ($urandom_range(9) == 0) step = $urandom >> $urandom_range(31, 4);
                else step = $urandom_range(300, 1);
                ctr = pool_last[k] + step;
                if (ctr == ZERO_COUNTER) ctr = 32'd1;
                offer(1'b1, TITLE_BYTES, pool_title[k], ctr);
                if (ctr > pool_last[k]) pool_last[k] = ctr;
            end
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow a full scan for stragglers
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (3 * (ENTRIES + 4)) @(posedge aclk);

        $display("checked %0d of %0d requests in %0d cycles", results_seen, sent, cycle_count);
        $display("inserts %0d, replays %0d, table full %0d, malformed %0d",
                 inserts_seen, replays_seen, full_seen, malformed_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/prc_pkg.sv
rtl/prc_ctrl.sv
rtl/prc_datapath.sv
rtl/per_title_replay_check.sv
sim/replay_checker.sv
sim/testbench.sv
